// File: rtl/scc_pkg.sv
`timescale 1ns / 1ps

package scc_pkg;

  localparam int POS_W    = 24;
  localparam int TIME_W   = 32;
  localparam int METRIC_W = 32;
  localparam int INDEX_W  = 16;
  localparam int COUNT_W  = 17;

  localparam int DELTA_W  = POS_W + 1;
  localparam int VEL_W    = DELTA_W + 1;
  localparam int DVEL_W   = VEL_W + 1;
  localparam int MUL_W    = VEL_W;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int RAD_W    = 2 * (PROD_W / 2 + 1);
  localparam int ROOT_W   = RAD_W / 2;

  localparam logic [METRIC_W-1:0] BOUND_RESET = 32'hFFFF_FFFE;
  localparam logic [METRIC_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    METRIC_NONE     = 2'd0,
    METRIC_DISTANCE = 2'd1,
    METRIC_SPEED    = 2'd2,
    METRIC_VCHANGE  = 2'd3
  } metric_t;

  typedef enum logic [1:0] {
    REG_DISTANCE_BOUND = 2'd0,
    REG_SPEED_BOUND    = 2'd1,
    REG_VCHANGE_BOUND  = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_A,
    S_SQ_B,
    S_SUM_A,
    S_SQRT_A,
    S_VEL,
    S_SQ_C,
    S_SQ_D,
    S_SUM_B,
    S_SQRT_B,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;
    logic [TIME_W-1:0]       timestamp;
    logic                    last_point;
  } point_t;

  typedef struct packed {
    logic                  failed;
    logic [1:0]            failed_metric;
    logic [INDEX_W-1:0]    fail_from;
    logic [INDEX_W-1:0]    fail_to;
    logic [METRIC_W-1:0]   fail_value;
    logic [METRIC_W-1:0]   max_distance;
    logic [METRIC_W-1:0]   max_speed;
    logic [METRIC_W-1:0]   max_velocity_change;
    logic [COUNT_W-1:0]    point_count;
  } result_t;

  typedef struct packed {
    logic [METRIC_W-1:0] distance;
    logic [METRIC_W-1:0] speed;
    logic [METRIC_W-1:0] vchange;
  } bounds_t;

endpackage

// File: rtl/scc_queue.sv
`timescale 1ns / 1ps

module scc_queue #(
  parameter int W = 81
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         head_valid,
  input  logic         pop,
  output logic [W-1:0] head_data
);

  logic [W-1:0] entries [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/scc_div.sv
`timescale 1ns / 1ps

module scc_div #(
  parameter int ND = 25,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [ND-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [ND-1:0] quotient
);

  localparam int CNW = $clog2(ND + 1);

  logic [DW:0]    rem;
  logic [ND-1:0]  quo;
  logic [DW-1:0]  dsr;
  logic [CNW-1:0] cnt;
  logic [DW:0]    rem_s;
  logic [DW:0]    diff;
  logic           ge;

  assign rem_s    = {rem[DW-1:0], quo[ND-1]};
  assign ge       = (rem_s >= {1'b0, dsr});
  assign diff     = rem_s - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(ND);
    end else if (busy) begin
      cnt <= cnt - CNW'(1);
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff : rem_s;
      quo <= {quo[ND-2:0], ge};
    end
  end

endmodule

// File: rtl/scc_sqrt.sv
`timescale 1ns / 1ps

module scc_sqrt #(
  parameter int IW = 54
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IW-1:0]   radicand,
  output logic            busy,
  output logic [IW/2-1:0] root
);

  localparam int RW  = IW / 2;
  localparam int CNW = $clog2(RW + 1);

  logic [IW-1:0]  rad;
  logic [RW:0]    rem;
  logic [CNW-1:0] cnt;
  logic [RW+2:0]  rem_s;
  logic [RW+2:0]  trial;
  logic [RW+2:0]  diff;
  logic           ge;

  assign rem_s = {rem, rad[IW-1:IW-2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = (rem_s >= trial);
  assign diff  = rem_s - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(RW);
    end else if (busy) begin
      cnt <= cnt - CNW'(1);
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[IW-3:0], 2'b00};
      rem  <= ge ? diff[RW:0] : rem_s[RW:0];
      root <= {root[RW-2:0], ge};
    end
  end

endmodule

// File: rtl/scc_back.sv
`timescale 1ns / 1ps

module scc_back #(
  parameter int MAX_POINTS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  output logic             pop,
  input  scc_pkg::point_t  head_data,
  input  scc_pkg::bounds_t bounds,
  output logic             result_valid,
  input  logic             result_ready,
  output scc_pkg::result_t result
);

  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int CW = (PW > scc_pkg::COUNT_W) ? PW : scc_pkg::COUNT_W;
  localparam int DW = scc_pkg::DELTA_W;
  localparam int VW = scc_pkg::VEL_W;
  localparam int GW = scc_pkg::DVEL_W;
  localparam int MW = scc_pkg::MUL_W;
  localparam int QW = scc_pkg::PROD_W;
  localparam int RW = scc_pkg::RAD_W;
  localparam int OW = scc_pkg::ROOT_W;
  localparam int TW = scc_pkg::TIME_W;
  localparam int MTW = scc_pkg::METRIC_W;
  localparam int IXW = scc_pkg::INDEX_W;

  scc_pkg::state_t state;
  scc_pkg::state_t state_next;

  scc_pkg::point_t cur;
  logic [PW-1:0]   point_index;
  logic signed [scc_pkg::POS_W-1:0] prev_x;
  logic signed [scc_pkg::POS_W-1:0] prev_y;
  logic [TW-1:0]   prev_time;
  logic signed [VW-1:0] prev_vel_x;
  logic signed [VW-1:0] prev_vel_y;
  logic [MTW-1:0]  best_distance;
  logic [IXW-1:0]  best_distance_start;
  logic [MTW-1:0]  best_speed;
  logic [IXW-1:0]  best_speed_start;
  logic [MTW-1:0]  best_vchange;
  logic [IXW-1:0]  best_vchange_start;

  logic [DW-1:0]   mag_x;
  logic [DW-1:0]   mag_y;
  logic            neg_x;
  logic            neg_y;
  logic [TW-1:0]   dtu;
  logic            pos;
  logic signed [VW-1:0] vel_x;
  logic signed [VW-1:0] vel_y;
  logic [MW-1:0]   dmag_x;
  logic [MW-1:0]   dmag_y;
  logic [OW-1:0]   len;
  logic [QW-1:0]   prod;
  logic [QW-1:0]   acc;

  logic signed [DW-1:0] dx_w;
  logic signed [DW-1:0] dy_w;
  logic [TW-1:0]   dt_w;
  logic signed [GW-1:0] dvx_w;
  logic signed [GW-1:0] dvy_w;
  logic [MW-1:0]   mul_op;
  logic [RW-1:0]   radicand;
  logic            counted;
  logic            first_point;
  logic            out_free;

  logic            sqrt_start;
  logic            sqrt_busy;
  logic [OW-1:0]   sqrt_root;
  logic            div0_start;
  logic            div1_start;
  logic            div0_busy;
  logic            div1_busy;
  logic [DW-1:0]   div0_num;
  logic [DW-1:0]   div0_q;
  logic [DW-1:0]   div1_q;

  logic [MTW-1:0]  len_m;
  logic [MTW-1:0]  spd;
  logic [MTW-1:0]  vchange;
  logic [CW-1:0]   index_w;
  logic [CW-1:0]   from_w;
  logic [IXW-1:0]  from16;
  scc_pkg::metric_t fail_metric;
  logic [IXW-1:0]  fail_start;
  logic [MTW-1:0]  fail_val;

  assign dx_w = {head_data.x_pos[scc_pkg::POS_W-1], head_data.x_pos}
              - {prev_x[scc_pkg::POS_W-1], prev_x};
  assign dy_w = {head_data.y_pos[scc_pkg::POS_W-1], head_data.y_pos}
              - {prev_y[scc_pkg::POS_W-1], prev_y};
  assign dt_w = head_data.timestamp - prev_time;
  assign dvx_w = {vel_x[VW-1], vel_x} - {prev_vel_x[VW-1], prev_vel_x};
  assign dvy_w = {vel_y[VW-1], vel_y} - {prev_vel_y[VW-1], prev_vel_y};
  assign counted     = (point_index < PW'(MAX_POINTS));
  assign first_point = (point_index == '0);
  assign out_free    = !result_valid || result_ready;

  assign index_w = CW'(point_index);
  assign from_w  = index_w - CW'(1);
  assign from16  = from_w[IXW-1:0];
  assign len_m   = MTW'(len);
  assign vchange = MTW'(sqrt_root);
  assign radicand = RW'(acc) + RW'(prod);
  assign div0_num = (state == scc_pkg::S_VEL) ? len[DW-1:0] : mag_x;

  always_comb begin
    if (pos) begin
      spd = MTW'(div0_q);
    end else if (len == '0) begin
      spd = '0;
    end else begin
      spd = scc_pkg::ALL_ONES;
    end
  end

  always_comb begin
    case (state)
      scc_pkg::S_SQ_A: mul_op = MW'(mag_x);
      scc_pkg::S_SQ_B: mul_op = MW'(mag_y);
      scc_pkg::S_SQ_C: mul_op = dmag_x;
      scc_pkg::S_SQ_D: mul_op = dmag_y;
      default:         mul_op = '0;
    endcase
  end

  always_comb begin
    if (best_distance > bounds.distance) begin
      fail_metric = scc_pkg::METRIC_DISTANCE;
      fail_start  = best_distance_start;
      fail_val    = best_distance;
    end else if (best_speed > bounds.speed) begin
      fail_metric = scc_pkg::METRIC_SPEED;
      fail_start  = best_speed_start;
      fail_val    = best_speed;
    end else if (best_vchange > bounds.vchange) begin
      fail_metric = scc_pkg::METRIC_VCHANGE;
      fail_start  = best_vchange_start;
      fail_val    = best_vchange;
    end else begin
      fail_metric = scc_pkg::METRIC_NONE;
      fail_start  = '0;
      fail_val    = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      scc_pkg::S_IDLE: begin
        if (head_valid) begin
          state_next = (counted && !first_point) ? scc_pkg::S_SQ_A : scc_pkg::S_FINISH;
        end
      end
      scc_pkg::S_SQ_A:  state_next = scc_pkg::S_SQ_B;
      scc_pkg::S_SQ_B:  state_next = scc_pkg::S_SUM_A;
      scc_pkg::S_SUM_A: state_next = scc_pkg::S_SQRT_A;
      scc_pkg::S_SQRT_A: begin
        if (!sqrt_busy && !div0_busy && !div1_busy) begin
          state_next = scc_pkg::S_VEL;
        end
      end
      scc_pkg::S_VEL:   state_next = scc_pkg::S_SQ_C;
      scc_pkg::S_SQ_C:  state_next = scc_pkg::S_SQ_D;
      scc_pkg::S_SQ_D:  state_next = scc_pkg::S_SUM_B;
      scc_pkg::S_SUM_B: state_next = scc_pkg::S_SQRT_B;
      scc_pkg::S_SQRT_B: begin
        if (!sqrt_busy && !div0_busy) begin
          state_next = scc_pkg::S_UPDATE;
        end
      end
      scc_pkg::S_UPDATE: state_next = scc_pkg::S_FINISH;
      scc_pkg::S_FINISH: begin
        if (!cur.last_point || out_free) begin
          state_next = scc_pkg::S_IDLE;
        end
      end
      default: state_next = scc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    sqrt_start = 1'b0;
    div0_start = 1'b0;
    div1_start = 1'b0;
    case (state)
      scc_pkg::S_IDLE:  pop = head_valid;
      scc_pkg::S_SQ_A: begin
        div0_start = 1'b1;
        div1_start = 1'b1;
      end
      scc_pkg::S_SUM_A: sqrt_start = 1'b1;
      scc_pkg::S_VEL:   div0_start = 1'b1;
      scc_pkg::S_SUM_B: sqrt_start = 1'b1;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  scc_sqrt #(
    .IW (RW)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  scc_div #(
    .ND (DW),
    .DW (TW)
  ) u_div0 (
    .clk      (clk),
    .rst      (rst),
    .start    (div0_start),
    .dividend (div0_num),
    .divisor  (dtu),
    .busy     (div0_busy),
    .quotient (div0_q)
  );

  scc_div #(
    .ND (DW),
    .DW (TW)
  ) u_div1 (
    .clk      (clk),
    .rst      (rst),
    .start    (div1_start),
    .dividend (mag_y),
    .divisor  (dtu),
    .busy     (div1_busy),
    .quotient (div1_q)
  );

  always_ff @(posedge clk) begin
    if (state == scc_pkg::S_IDLE && head_valid) begin
      cur   <= head_data;
      mag_x <= dx_w[DW-1] ? DW'(-dx_w) : DW'(dx_w);
      mag_y <= dy_w[DW-1] ? DW'(-dy_w) : DW'(dy_w);
      neg_x <= dx_w[DW-1];
      neg_y <= dy_w[DW-1];
      dtu   <= dt_w;
      pos   <= (dt_w != '0) && !dt_w[TW-1];
    end
    case (state)
      scc_pkg::S_SQ_A: prod <= mul_op * mul_op;
      scc_pkg::S_SQ_B: begin
        acc  <= prod;
        prod <= mul_op * mul_op;
      end
      scc_pkg::S_SQ_C: prod <= mul_op * mul_op;
      scc_pkg::S_SQ_D: begin
        acc  <= prod;
        prod <= mul_op * mul_op;
      end
      scc_pkg::S_SQRT_A: begin
        len <= sqrt_root;
        if (pos) begin
          vel_x <= neg_x ? -VW'(div0_q) : VW'(div0_q);
          vel_y <= neg_y ? -VW'(div1_q) : VW'(div1_q);
        end else begin
          vel_x <= '0;
          vel_y <= '0;
        end
      end
      scc_pkg::S_VEL: begin
        dmag_x <= dvx_w[GW-1] ? MW'(-dvx_w) : MW'(dvx_w);
        dmag_y <= dvy_w[GW-1] ? MW'(-dvy_w) : MW'(dvy_w);
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= scc_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == scc_pkg::S_FINISH && cur.last_point && out_free) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == scc_pkg::S_FINISH && cur.last_point && out_free) begin
      result.failed              <= (fail_metric != scc_pkg::METRIC_NONE);
      result.failed_metric       <= fail_metric;
      result.fail_from           <= fail_start;
      result.fail_to             <= (fail_metric != scc_pkg::METRIC_NONE)
                                    ? fail_start + IXW'(1) : '0;
      result.fail_value          <= fail_val;
      result.max_distance        <= best_distance;
      result.max_speed           <= best_speed;
      result.max_velocity_change <= best_vchange;
      result.point_count         <= (index_w > CW'({scc_pkg::COUNT_W{1'b1}}))
                                    ? '1 : index_w[scc_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (state == scc_pkg::S_FINISH && cur.last_point && out_free)) begin
      point_index         <= '0;
      prev_x              <= '0;
      prev_y              <= '0;
      prev_time           <= '0;
      prev_vel_x          <= '0;
      prev_vel_y          <= '0;
      best_distance       <= '0;
      best_distance_start <= '0;
      best_speed          <= '0;
      best_speed_start    <= '0;
      best_vchange        <= '0;
      best_vchange_start  <= '0;
    end else if (state == scc_pkg::S_IDLE && head_valid && counted && first_point) begin
      prev_x      <= head_data.x_pos;
      prev_y      <= head_data.y_pos;
      prev_time   <= head_data.timestamp;
      point_index <= point_index + PW'(1);
    end else if (state == scc_pkg::S_UPDATE) begin
      if (len_m > best_distance) begin
        best_distance       <= len_m;
        best_distance_start <= from16;
      end
      if (spd > best_speed) begin
        best_speed       <= spd;
        best_speed_start <= from16;
      end
      if (point_index >= PW'(2) && vchange > best_vchange) begin
        best_vchange       <= vchange;
        best_vchange_start <= from16;
      end
      prev_vel_x  <= vel_x;
      prev_vel_y  <= vel_y;
      prev_x      <= cur.x_pos;
      prev_y      <= cur.y_pos;
      prev_time   <= cur.timestamp;
      point_index <= point_index + PW'(1);
    end
  end

  a_failed_matches_metric: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.failed == (result.failed_metric != scc_pkg::METRIC_NONE)))
    else $error("failed flag disagrees with failed_metric");

  a_pass_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.failed_metric == scc_pkg::METRIC_NONE)
      |-> (result.fail_value == '0 && result.fail_from == '0 && result.fail_to == '0))
    else $error("passing result carries failure fields");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    point_index <= PW'(MAX_POINTS))
    else $error("point index beyond limit");

  a_sqrt_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_busy)
    else $error("square root restarted while busy");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("pending result dropped");

endmodule

// File: rtl/stroke_continuity_checker.sv
`timescale 1ns / 1ps

// Checks one pen or touch stroke at a time. Points enter on the point channel
// (valid/ready), one item per point, with last_point set on the final one.
// Only the final point produces an item on the result channel, carrying the
// maxima of segment length, speed and velocity change and the first bound
// exceeded in the order distance, speed, velocity change. Bounds are written
// over the APB port at 0x0, 0x4, 0x8. For a point that forms a segment, two
// 27-step square roots run one after the other, with the bit-serial dividers
// overlapped. The first point of a stroke, and points past MAX_POINTS, skip to
// S_FINISH; the result item is registered there once the output is free.
// A two-entry queue takes points while the previous one is being processed.
// If the receiver stalls, the result is held and the block finishes the next
// stroke's points until it has another result to deliver, then waits.
// Reset clears the stroke state and sets every bound to 0xFFFFFFFE.
module stroke_continuity_checker #(
  parameter int MAX_POINTS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_ready,
  input  scc_pkg::point_t  point,
  output logic             result_valid,
  input  logic             result_ready,
  output scc_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int PTW = $bits(scc_pkg::point_t);

  scc_pkg::bounds_t   bounds;
  scc_pkg::reg_index_t reg_sel;
  logic               head_valid;
  logic               pop;
  logic [PTW-1:0]     head_bits;
  scc_pkg::point_t    head_data;

  assign pready    = 1'b1;
  assign reg_sel   = scc_pkg::reg_index_t'(paddr[3:2]);
  assign head_data = head_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.distance <= scc_pkg::BOUND_RESET;
      bounds.speed    <= scc_pkg::BOUND_RESET;
      bounds.vchange  <= scc_pkg::BOUND_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        scc_pkg::REG_DISTANCE_BOUND: bounds.distance <= pwdata;
        scc_pkg::REG_SPEED_BOUND:    bounds.speed    <= pwdata;
        scc_pkg::REG_VCHANGE_BOUND:  bounds.vchange  <= pwdata;
        default:                     bounds          <= bounds;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      scc_pkg::REG_DISTANCE_BOUND: prdata = bounds.distance;
      scc_pkg::REG_SPEED_BOUND:    prdata = bounds.speed;
      scc_pkg::REG_VCHANGE_BOUND:  prdata = bounds.vchange;
      default:                     prdata = '0;
    endcase
  end

  scc_queue #(
    .W (PTW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (point_valid),
    .push_ready (point_ready),
    .push_data  (point),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_bits)
  );

  scc_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .pop          (pop),
    .head_data    (head_data),
    .bounds       (bounds),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: sim/tb_stroke_continuity_checker.sv
`timescale 1ns / 1ps

module tb_stroke_continuity_checker;

  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_ready;
  scc_pkg::point_t point = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  scc_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  stroke_continuity_checker DUT (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_ready(point_ready), .point(point),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [31:0] lim_dist, lim_speed, lim_vchg;
  logic signed [63:0] last_x, last_y, last_vx, last_vy;
  logic [31:0] last_t;
  int unsigned pt_idx;
  logic [31:0] top_dist, top_speed, top_vchg;
  logic [15:0] top_dist_at, top_speed_at, top_vchg_at;

  scc_pkg::point_t pending_points[$];
  scc_pkg::result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] vec_len(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic [63:0] ua, ub, r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r = root_floor(ua * ua + ub * ub);
    return r > 64'hFFFF_FFFF ? scc_pkg::ALL_ONES : r[31:0];
  endfunction

  task automatic clear_stroke();
    last_x = 0; last_y = 0; last_t = 0; last_vx = 0; last_vy = 0;
    pt_idx = 0;
    top_dist = 0; top_speed = 0; top_vchg = 0;
    top_dist_at = 0; top_speed_at = 0; top_vchg_at = 0;
  endtask

  task automatic predict_point(input scc_pkg::point_t p);
    logic signed [63:0] x, y, dx, dy, vx, vy;
    logic [31:0] dt, len, spd, vc, from;
    scc_pkg::result_t r;
    x = 64'(p.x_pos);
    y = 64'(p.y_pos);
    if (pt_idx < 65536) begin
      if (pt_idx >= 1) begin
        dx = x - last_x;
        dy = y - last_y;
        dt = p.timestamp - last_t;
        len = vec_len(dx, dy);
        vx = 0;
        vy = 0;
        from = pt_idx - 1;
        if (dt != 0 && dt < 32'h8000_0000) begin
          spd = len / dt;
          vx = dx / $signed({32'd0, dt});
          vy = dy / $signed({32'd0, dt});
        end else begin
          spd = (len == 0) ? 32'd0 : scc_pkg::ALL_ONES;
        end
        if (len > top_dist) begin top_dist = len; top_dist_at = from[15:0]; end
        if (spd > top_speed) begin top_speed = spd; top_speed_at = from[15:0]; end
        if (pt_idx >= 2) begin
          vc = vec_len(vx - last_vx, vy - last_vy);
          if (vc > top_vchg) begin top_vchg = vc; top_vchg_at = from[15:0]; end
        end
        last_vx = vx;
        last_vy = vy;
      end
      last_x = x;
      last_y = y;
      last_t = p.timestamp;
      pt_idx++;
    end
    if (p.last_point) begin
      r = '0;
      if (top_dist > lim_dist) begin
        r.failed_metric = scc_pkg::METRIC_DISTANCE; r.fail_from = top_dist_at;
        r.fail_value = top_dist;
      end else if (top_speed > lim_speed) begin
        r.failed_metric = scc_pkg::METRIC_SPEED; r.fail_from = top_speed_at;
        r.fail_value = top_speed;
      end else if (top_vchg > lim_vchg) begin
        r.failed_metric = scc_pkg::METRIC_VCHANGE; r.fail_from = top_vchg_at;
        r.fail_value = top_vchg;
      end
      r.failed = (r.failed_metric != scc_pkg::METRIC_NONE);
      r.fail_to = r.failed ? r.fail_from + 16'd1 : 16'd0;
      r.max_distance = top_dist;
      r.max_speed = top_speed;
      r.max_velocity_change = top_vchg;
      r.point_count = pt_idx > 32'h1FFFF ? 17'h1FFFF : pt_idx[16:0];
      expected_results.push_back(r);
      clear_stroke();
    end
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (!point_valid || point_ready) begin
      if (point_valid) predict_point(point);
      if (send_gap > 0) begin
        send_gap--;
        point_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point <= pending_points.pop_front();
        point_valid <= 1'b1;
        send_gap = ($urandom_range(0, 9) < 6) ? 0 :
                   ($urandom_range(0, 9) == 0 ? $urandom_range(20, 200) :
                   $urandom_range(1, 4));
      end else begin
        point_valid <= 1'b0;
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    scc_pkg::result_t e;
    cycles++;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (result.failed !== e.failed) begin
            $error("failed exp %0d got %0d", e.failed, result.failed); errors++; end
          if (result.failed_metric !== e.failed_metric) begin
            $error("failed_metric exp %0d got %0d", e.failed_metric,
                   result.failed_metric); errors++; end
          if (result.fail_from !== e.fail_from) begin
            $error("fail_from exp %0d got %0d", e.fail_from, result.fail_from);
            errors++; end
          if (result.fail_to !== e.fail_to) begin
            $error("fail_to exp %0d got %0d", e.fail_to, result.fail_to); errors++; end
          if (result.fail_value !== e.fail_value) begin
            $error("fail_value exp %h got %h", e.fail_value, result.fail_value);
            errors++; end
          if (result.max_distance !== e.max_distance) begin
            $error("max_distance exp %h got %h", e.max_distance, result.max_distance);
            errors++; end
          if (result.max_speed !== e.max_speed) begin
            $error("max_speed exp %h got %h", e.max_speed, result.max_speed);
            errors++; end
          if (result.max_velocity_change !== e.max_velocity_change) begin
            $error("max_velocity_change exp %h got %h", e.max_velocity_change,
                   result.max_velocity_change); errors++; end
          if (result.point_count !== e.point_count) begin
            $error("point_count exp %0d got %0d", e.point_count, result.point_count);
            errors++; end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        recv_gap = ($urandom_range(0, 9) < 6) ? 0 :
                   ($urandom_range(0, 19) == 0 ? $urandom_range(20, 300) :
                   $urandom_range(1, 4));
      end
    end
    if (cycles >= LIMIT) begin
      $display("tb_stroke_continuity_checker failed");
      $finish;
    end
  end

  task automatic apb_write(input scc_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      scc_pkg::REG_DISTANCE_BOUND: lim_dist = val;
      scc_pkg::REG_SPEED_BOUND: lim_speed = val;
      scc_pkg::REG_VCHANGE_BOUND: lim_vchg = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_points.size() > 0 || point_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic scc_pkg::point_t mk(input int x, input int y,
                                         input logic [31:0] t, input bit l);
    scc_pkg::point_t p;
    p.x_pos = 24'(x); p.y_pos = 24'(y); p.timestamp = t; p.last_point = l;
    return p;
  endfunction

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return scc_pkg::BOUND_RESET;
      3: return $urandom_range(0, 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random_stroke(input int len);
    logic [31:0] t;
    int x, y, step;
    t = $urandom;
    x = $urandom_range(0, 1) ? $signed($urandom) >>> 8 : $urandom_range(0, 2000) - 1000;
    y = $urandom_range(0, 1) ? $signed($urandom) >>> 8 : $urandom_range(0, 2000) - 1000;
    step = (1 << $urandom_range(0, 22));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) t = t - $urandom_range(0, 3);
      else if ($urandom_range(0, 29) == 0) t = $urandom;
      else t = t + $urandom_range(1, 50);
      if ($urandom_range(0, 19) == 0) begin
        x = $signed($urandom) >>> 8; y = $signed($urandom) >>> 8;
      end else begin
        x = x + $urandom_range(0, 2 * step) - step;
        y = y + $urandom_range(0, 2 * step) - step;
        if (x > 8388607) x = 8388607;
        if (x < -8388608) x = -8388608;
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
      end
      pending_points.push_back(mk(x, y, t, i == len - 1));
    end
  endtask

  initial begin
    int sent;
    lim_dist = scc_pkg::BOUND_RESET;
    lim_speed = scc_pkg::BOUND_RESET;
    lim_vchg = scc_pkg::BOUND_RESET;
    clear_stroke();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: single point, extremes, zero and negative steps.
    pending_points.push_back(mk(8388607, -8388608, 32'hFFFF_FFFF, 1));
    pending_points.push_back(mk(0, 0, 0, 0));
    pending_points.push_back(mk(0, 0, 0, 1));
    pending_points.push_back(mk(-8388608, -8388608, 100, 0));
    pending_points.push_back(mk(8388607, 8388607, 101, 0));
    pending_points.push_back(mk(-8388608, 8388607, 101, 0));
    pending_points.push_back(mk(8388607, -8388608, 90, 0));
    pending_points.push_back(mk(8388607, -8388608, 32'h8000_005A, 1));
    pending_points.push_back(mk(0, 0, 32'hFFFF_FFFE, 0));
    pending_points.push_back(mk(300, -300, 1, 0));
    pending_points.push_back(mk(-300, 300, 4, 0));
    pending_points.push_back(mk(-300, 300, 4, 1));
    wait_idle();
    apb_write(scc_pkg::REG_DISTANCE_BOUND, 32'd0);
    apb_write(scc_pkg::REG_UNUSED, 32'd5);
    pending_points.push_back(mk(0, 0, 0, 0));
    pending_points.push_back(mk(1, 0, 1, 1));
    wait_idle();
    apb_write(scc_pkg::REG_DISTANCE_BOUND, 32'hFFFF_FFFF);
    apb_write(scc_pkg::REG_SPEED_BOUND, 32'd0);
    apb_write(scc_pkg::REG_VCHANGE_BOUND, 32'd0);
    pending_points.push_back(mk(0, 0, 0, 0));
    pending_points.push_back(mk(0, 0, 5, 0));
    pending_points.push_back(mk(100, 0, 6, 1));
    wait_idle();
    apb_write(scc_pkg::REG_SPEED_BOUND, 32'hFFFF_FFFF);
    pending_points.push_back(mk(0, 0, 0, 0));
    pending_points.push_back(mk(50, 50, 0, 0));
    pending_points.push_back(mk(-50, 50, 2, 1));
    wait_idle();

    // Long hold-off on the receiver while short strokes keep coming.
    hold_off = 3000;
    for (int i = 0; i < 8; i++) add_random_stroke($urandom_range(1, 4));
    wait_idle();

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      apb_write(scc_pkg::REG_DISTANCE_BOUND, rand_bound());
      apb_write(scc_pkg::REG_SPEED_BOUND, rand_bound());
      apb_write(scc_pkg::REG_VCHANGE_BOUND, rand_bound());
      for (int k = 0; k < 170; ) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 20);
        add_random_stroke(n);
        k += n;
        sent += n;
      end
      wait_idle();
    end
    wait_idle();
    if (errors == 0) begin
      $display("tb_stroke_continuity_checker passed");
    end else begin
      $display("tb_stroke_continuity_checker failed");
    end
    $finish;
  end
endmodule
